@@ rtl/fpa_pkg.sv @@
// Package: constants, types and the truncated signed Q2.32 multiply for the atan2 pipeline.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int IN_W    = 64;
    localparam int ANGLE_W = 35;
    localparam int FRAC_W  = 32;
    localparam int A_W     = 33;

    localparam logic signed [33:0] C3 = -34'sd199700839;
    localparam logic signed [33:0] C2 = 34'sd684249364;
    localparam logic signed [33:0] C1 = 34'sd1407129056;
    localparam logic signed [35:0] PI_Q   = 36'sd13493037705;
    localparam logic signed [35:0] PI_2_Q = 36'sd6746518852;

    typedef struct packed {
        logic ygtx;
        logic xneg;
        logic yneg;
    } t_oct;

    function automatic logic signed [33:0] fx_mul34(input logic signed [33:0] a,
                                                    input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = a * b;
            fx_mul34 = p[65:32];
        end
    endfunction

endpackage

@@ rtl/fpa_if.sv @@
// Interface: valid/ready channel carrying one payload word.
`timescale 1ns / 1ps
interface fpa_if #(parameter int W = 8) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fpa_div.sv @@
// Module: pipelined radix-2 divider, one quotient bit per stage, 32 stages.
`timescale 1ns / 1ps
module fpa_div
    import fpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [IN_W-2:0]      i_num,
    input  logic [IN_W-2:0]      i_den,
    input  t_oct                 i_oct,
    input  logic                 i_one,
    output logic                 o_valid,
    output logic [A_W-1:0]       o_quot,
    output t_oct                 o_oct
);
    localparam int N = FRAC_W;
    logic              r_v   [N];
    logic [IN_W-1:0]   r_rem [N];
    logic [IN_W-2:0]   r_den [N];
    logic [N-1:0]      r_q   [N];
    t_oct              r_oct [N];
    logic              r_one [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < N; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [IN_W-1:0] t;
            t = {i_num, 1'b0};
            if (t >= {1'b0, i_den}) begin
                r_rem[0] <= t - {1'b0, i_den};
                r_q[0]   <= {{(N-1){1'b0}}, 1'b1};
            end else begin
                r_rem[0] <= t;
                r_q[0]   <= '0;
            end
            r_den[0] <= i_den;
            r_oct[0] <= i_oct;
            r_one[0] <= i_one;
            for (int k = 1; k < N; k++) begin
                logic [IN_W-1:0] u;
                u = {r_rem[k-1][IN_W-2:0], 1'b0};
                if (u >= {1'b0, r_den[k-1]}) begin
                    r_rem[k] <= u - {1'b0, r_den[k-1]};
                    r_q[k]   <= {r_q[k-1][N-2:0], 1'b1};
                end else begin
                    r_rem[k] <= u;
                    r_q[k]   <= {r_q[k-1][N-2:0], 1'b0};
                end
                r_den[k] <= r_den[k-1];
                r_oct[k] <= r_oct[k-1];
                r_one[k] <= r_one[k-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_oct   = r_oct[N-1];
    assign o_quot  = r_one[N-1] ? {1'b1, {N{1'b0}}} : {1'b0, r_q[N-1]};
endmodule

@@ rtl/fixed_point_atan2_unit.sv @@
// Top level: pipelined fixed-point atan2 with polynomial approximation.
//   channel   dir  payload
//   i_in      in   {y_coord[63:0], x_coord[63:0]}  (data[127:64] = y)
//   o_out     out  angle[34:0]
// One word per cycle while the output is not stalled. The 32-stage divider sets depth.
// Reset clears all valid bits. A stall freezes the whole pipeline; the output
// register is the last stage, so input ready follows output ready or an empty slot.
`timescale 1ns / 1ps
module fixed_point_atan2_unit
    import fpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fpa_if.sink   i_in,
    fpa_if.source o_out
);
    logic en;
    logic r_v0;
    logic [IN_W-2:0] r_lo, r_hi;
    t_oct r_oct0;
    logic r_one0;

    logic          dv;
    logic [A_W-1:0] dq;
    t_oct          doct;

    logic              r_v [7];
    logic signed [33:0] r_a [6];
    logic signed [33:0] r_s [6];
    logic signed [33:0] r_t [6];
    t_oct              r_o [6];
    logic signed [35:0] r_ang;

    assign en = o_out.ready || !r_v[6];
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [IN_W-1:0] y, x;
            logic [IN_W-2:0] ay, ax;
            y = i_in.data[2*IN_W-1:IN_W];
            x = i_in.data[IN_W-1:0];
            ay = y[IN_W-1] ? ((y[IN_W-2:0] == '0) ? '1 : (IN_W-1)'(-y)) : y[IN_W-2:0];
            ax = x[IN_W-1] ? ((x[IN_W-2:0] == '0) ? '1 : (IN_W-1)'(-x)) : x[IN_W-2:0];
            r_hi <= (ax > ay) ? ax : ((ay == '0) ? {{(IN_W-2){1'b0}}, 1'b1} : ay);
            r_lo <= (ax > ay) ? ay : ax;
            r_one0 <= (ax == ay) && (ax != '0);
            r_oct0 <= '{ygtx: ay > ax, xneg: x[IN_W-1], yneg: y[IN_W-1]};
        end
    end

    fpa_div u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v0),
        .i_num(r_one0 ? '0 : r_lo), .i_den(r_hi), .i_oct(r_oct0), .i_one(r_one0),
        .o_valid(dv), .o_quot(dq), .o_oct(doct)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= dv;
            for (int k = 1; k < 7; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [35:0] r;
            r_a[0] <= $signed({1'b0, dq});
            r_o[0] <= doct;
            r_s[0] <= '0;
            r_t[0] <= '0;
            r_a[1] <= r_a[0]; r_o[1] <= r_o[0];
            r_s[1] <= fx_mul34(r_a[0], r_a[0]);
            r_t[1] <= '0;
            r_a[2] <= r_a[1]; r_o[2] <= r_o[1]; r_s[2] <= r_s[1];
            r_t[2] <= fx_mul34(C3, r_s[1]) + C2;
            r_a[3] <= r_a[2]; r_o[3] <= r_o[2]; r_s[3] <= r_s[2];
            r_t[3] <= fx_mul34(r_t[2], r_s[2]) - C1;
            r_a[4] <= r_a[3]; r_o[4] <= r_o[3]; r_s[4] <= r_s[3];
            r_t[4] <= fx_mul34(r_t[3], r_s[3]);
            r_a[5] <= r_a[4]; r_o[5] <= r_o[4]; r_s[5] <= r_s[4];
            r_t[5] <= fx_mul34(r_t[4], r_a[4]) + r_a[4];
            r = 36'(r_t[5]);
            if (r_o[5].ygtx) r = PI_2_Q - r;
            if (r_o[5].xneg) r = PI_Q - r;
            if (r_o[5].yneg) r = -r;
            r_ang <= r;
        end
    end

    assign o_out.valid = r_v[6];
    assign o_out.data  = r_ang[ANGLE_W-1:0];

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("output moved under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready) else $error("ready low with empty output");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] |-> r_t[5] <= 34'sd4294967296 && r_t[5] >= 0)
        else $error("base angle out of range");
`endif
endmodule

@@ test/tb_fixed_point_atan2_unit.sv @@
// Testbench: drives coordinate words into the atan2 pipeline and checks each angle word.
`timescale 1ns / 1ps
module tb_fixed_point_atan2_unit;
    import fpa_pkg::*;

    localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_V = 64'h0000_0001_0000_0000;
    localparam logic [63:0] C3_V = -64'sd199700839;
    localparam logic [63:0] C2_V = 64'd684249364;
    localparam logic [63:0] C1_V = 64'd1407129056;
    localparam logic [63:0] PI_V = 64'd13493037705;
    localparam logic [63:0] PI2_V = 64'd6746518852;
    localparam int N_RAND = 1400;
    localparam int LAT = 40;

    typedef struct {
        logic [63:0] y;
        logic [63:0] x;
        bit          known;
        logic [34:0] angle;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    fpa_if #(.W(128)) in_ch  (i_clk);
    fpa_if #(.W(ANGLE_W)) out_ch (i_clk);

    fixed_point_atan2_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    logic [34:0] angle_q[$];
    int          errors;
    int          n_sent;
    int          n_got;
    bit          hold_sink;
    bit          stim_done;
    t_row        rows[$];

    function automatic logic [63:0] mag(logic [63:0] v);
        if (!v[63]) return v;
        if (v == MIN_V) return MAX_V;
        return -v;
    endfunction

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        return p[95:32];
    endfunction

    function automatic logic [63:0] ratio(logic [63:0] num, logic [63:0] den);
        logic [95:0] n;
        logic [95:0] q;
        if (den == 0) return 0;
        if (num >= den) return ONE_V;
        n = {num, 32'd0};
        q = n / den;
        return q[63:0];
    endfunction

    function automatic logic [34:0] atan2_angle(logic [63:0] y, logic [63:0] x);
        logic [63:0] ay, ax, hi, lo, a, s, t, r;
        ay = mag(y);
        ax = mag(x);
        hi = (ax > ay) ? ax : ay;
        lo = (ax > ay) ? ay : ax;
        a = ratio(lo, hi);
        s = qmul(a, a);
        t = qmul(C3_V, s) + C2_V;
        t = qmul(t, s) - C1_V;
        r = qmul(qmul(t, s), a) + a;
        if (ay > ax) r = PI2_V - r;
        if (x[63]) r = PI_V - r;
        if (y[63]) r = -r;
        return r[34:0];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return MIN_V;
            1: return MAX_V;
            2: return 0;
            3: return $signed($urandom_range(0, 2000)) - 1000;
            4: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
            default: return rand64();
        endcase
    endfunction

    task automatic add_row(logic [63:0] y, logic [63:0] x, bit known, logic [34:0] ang);
        t_row r;
        r.y = y; r.x = x; r.known = known; r.angle = ang;
        rows.push_back(r);
    endtask

    task automatic send(logic [63:0] y, logic [63:0] x, logic [34:0] ang);
        in_ch.valid <= 1'b1;
        in_ch.data  <= {y, x};
        angle_q.push_back(ang);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic gap();
        int n;
        if ($urandom_range(0, 2) != 0) return;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!stim_done || angle_q.size() != 0) begin
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_sink = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
        out_ch.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (angle_q.size() == 0) begin
                $error("unexpected word angle=%h", out_ch.data);
                errors++;
            end else begin
                if (out_ch.data !== angle_q[0]) begin
                    $error("angle expected %h actual %h", angle_q[0], out_ch.data);
                    errors++;
                end
                void'(angle_q.pop_front());
                n_got++;
            end
        end
    end

    initial begin
        logic [63:0] y, x;
        int wait_c;
        errors = 0; n_sent = 0; n_got = 0; hold_sink = 0; stim_done = 0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(0, 0, 1, 0);
        add_row(0, ONE_V, 1, 0);
        add_row(0, MAX_V, 1, 0);
        add_row(ONE_V, 0, 1, PI2_V[34:0]);
        add_row(-ONE_V, 0, 1, -PI2_V[34:0]);
        add_row(0, -ONE_V, 1, PI_V[34:0]);
        add_row(MIN_V, MIN_V, 0, 0);
        add_row(MAX_V, MIN_V, 0, 0);
        add_row(MIN_V, MAX_V, 0, 0);
        add_row(MAX_V, MAX_V, 0, 0);
        add_row(MIN_V, 0, 0, 0);
        add_row(0, MIN_V, 0, 0);
        add_row(ONE_V, ONE_V, 0, 0);
        add_row(-ONE_V, -ONE_V, 0, 0);
        add_row(ONE_V, -ONE_V, 0, 0);
        add_row(1, MAX_V, 0, 0);
        add_row(MAX_V, 1, 0, 0);
        add_row(-64'sd1, 64'sd1, 0, 0);
        add_row(64'sd3, -64'sd7, 0, 0);
        add_row(-64'sd7, -64'sd3, 0, 0);
        add_row(-64'sd1, 0, 0, 0);
        foreach (rows[i])
            send(rows[i].y, rows[i].x,
                 rows[i].known ? rows[i].angle : atan2_angle(rows[i].y, rows[i].x));

        for (int i = 0; i < N_RAND; i++) begin
            if (i == 300) hold_sink = 1;
            if (i == 700) begin
                in_ch.valid <= 1'b0;
                while (angle_q.size() != 0) @(posedge i_clk);
            end
            y = rand_coord();
            x = rand_coord();
            if ($urandom_range(0, 15) == 0) x = ($urandom_range(0, 1) ? y : -y);
            send(y, x, atan2_angle(y, x));
            if (i > 400) gap();
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;

        wait_c = 0;
        while (angle_q.size() != 0 && wait_c < 100000) begin
            @(posedge i_clk);
            wait_c++;
        end
        repeat (LAT + 10) @(posedge i_clk);
        $display("Sent %0d coordinate words (extremes, axes, octants, random),", n_sent);
        $display("checked %0d angles.", n_got);
        if (errors == 0 && angle_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/fpa_pkg.sv
rtl/fpa_if.sv
rtl/fpa_div.sv
rtl/fixed_point_atan2_unit.sv
test/tb_fixed_point_atan2_unit.sv
